// ===== rtl/hgpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hgpt_pkg
// shared widths, constants and types for the hexagonal tile picker
// ----------------------------------------------------------------------------
package hgpt_pkg;

    // default tiles per chunk edge
    localparam int TILES_PER_CHUNK_DEF = 24;

    // section size in 1/16 px
    localparam int SECT_W16 = 1920;
    localparam int SECT_H16 = 1455;

    // slope test constants: slope and edges in 1/64 px, HALF_X in px
    localparam int SLOPE_M   = 31;
    localparam int EDGE_HALF = 1860;
    localparam int EDGE_FULL = 3720;
    localparam int HALF_X    = 60;

    // field widths
    localparam int PT_W  = 28;   // point coordinate
    localparam int CFG_W = 10;   // chunk coordinate register
    localparam int IDX_W = 1;    // register index
    localparam int ORG_W = 29;   // chunk origin in 1/16 px
    localparam int RX_W  = 30;   // relative point, signed
    localparam int MAG_W = 29;   // relative point magnitude
    localparam int Q_W   = 19;   // section index magnitude
    localparam int R_W   = 11;   // remainder inside a section, 1/16 px
    localparam int OFS_W = 8;    // signed pixel offset inside a section
    localparam int SL_W  = 16;   // slope test arithmetic
    localparam int TC_W  = 20;   // unsaturated tile index
    localparam int REL_W = 18;
    localparam int ABS_W = 19;
    localparam int CT_W  = 19;   // chunk coordinate times tiles per chunk
    localparam int SUM_W = 20;   // relative plus chunk tile offset

    localparam int IN_W  = 56;
    localparam int OUT_W = 80;
    localparam int OUT_PAD = OUT_W - 2 * REL_W - 2 * ABS_W;

    localparam int STAGES = 7;

    typedef enum logic [IDX_W-1:0] {
        REG_CHUNK_COL = 1'b0,
        REG_CHUNK_ROW = 1'b1
    } cfg_reg_t;

    // advance enables for a module spanning two pipeline stages
    typedef struct packed {
        logic first;
        logic second;
    } pipe_en_t;

endpackage

// ===== rtl/hgpt_front.sv =====
// ----------------------------------------------------------------------------
// hgpt_front
// chunk-relative point and its sign/magnitude split (two stages)
// ----------------------------------------------------------------------------
module hgpt_front (
    input  logic                         clk,
    input  hgpt_pkg::pipe_en_t           en,
    input  logic signed [hgpt_pkg::PT_W-1:0]  point_x,
    input  logic signed [hgpt_pkg::PT_W-1:0]  point_y,
    input  logic signed [hgpt_pkg::ORG_W-1:0] origin_x,
    input  logic signed [hgpt_pkg::ORG_W-1:0] origin_y,
    output logic                         neg_x,
    output logic                         neg_y,
    output logic [hgpt_pkg::MAG_W-1:0]   mag_x,
    output logic [hgpt_pkg::MAG_W-1:0]   mag_y
);
    import hgpt_pkg::*;

    logic signed [RX_W-1:0] rel_x_reg;
    logic signed [RX_W-1:0] rel_y_reg;
    logic                   neg_x_reg;
    logic                   neg_y_reg;
    logic [MAG_W-1:0]       mag_x_reg;
    logic [MAG_W-1:0]       mag_y_reg;

    always_ff @(posedge clk)
    begin
        if (en.first)
        begin
            rel_x_reg <= RX_W'(point_x) - RX_W'(origin_x);
            rel_y_reg <= RX_W'(point_y) - RX_W'(origin_y);
        end
        if (en.second)
        begin
            neg_x_reg <= rel_x_reg[RX_W-1];
            neg_y_reg <= rel_y_reg[RX_W-1];
            mag_x_reg <= MAG_W'(rel_x_reg[RX_W-1] ? -rel_x_reg : rel_x_reg);
            mag_y_reg <= MAG_W'(rel_y_reg[RX_W-1] ? -rel_y_reg : rel_y_reg);
        end
    end

    assign neg_x = neg_x_reg;
    assign neg_y = neg_y_reg;
    assign mag_x = mag_x_reg;
    assign mag_y = mag_y_reg;

endmodule

// ===== rtl/hgpt_cdiv.sv =====
// ----------------------------------------------------------------------------
// hgpt_cdiv
// unsigned divide by a constant: reciprocal multiply, then one correction step
// ----------------------------------------------------------------------------
module hgpt_cdiv #(
    parameter int DIV = hgpt_pkg::SECT_W16
) (
    input  logic                       clk,
    input  hgpt_pkg::pipe_en_t         en,
    input  logic [hgpt_pkg::MAG_W-1:0] dividend,
    output logic [hgpt_pkg::Q_W-1:0]   quot,
    output logic [hgpt_pkg::R_W-1:0]   rem
);
    import hgpt_pkg::*;

    // floor(2^MAG_W / DIV) underestimates the quotient by at most one
    localparam longint MAGIC = (longint'(1) << MAG_W) / DIV;
    localparam int     MG_W  = $clog2(MAGIC + 1);
    localparam int     PR_W  = MAG_W + MG_W;

    localparam logic [MG_W-1:0]  MAGIC_C = MG_W'(MAGIC);
    localparam logic [MAG_W-1:0] DIV_C   = MAG_W'(DIV);

    logic [PR_W-1:0]  prod;
    logic [Q_W-1:0]   q_est_reg;
    logic [MAG_W-1:0] dvd_reg;
    logic [MAG_W-1:0] q_times_d;
    logic [MAG_W-1:0] r_est;
    logic             fix;
    logic [Q_W-1:0]   quot_reg;
    logic [R_W-1:0]   rem_reg;

    assign prod = PR_W'(dividend) * PR_W'(MAGIC_C);

    always_comb
    begin
        q_times_d = MAG_W'(MAG_W'(q_est_reg) * DIV_C);
        r_est     = dvd_reg - q_times_d;
        fix       = (r_est >= DIV_C);
    end

    always_ff @(posedge clk)
    begin
        if (en.first)
        begin
            q_est_reg <= Q_W'(prod >> MAG_W);
            dvd_reg   <= dividend;
        end
        if (en.second)
        begin
            quot_reg <= fix ? q_est_reg + Q_W'(1) : q_est_reg;
            rem_reg  <= R_W'(fix ? r_est - DIV_C : r_est);
        end
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/hgpt_pick.sv =====
// ----------------------------------------------------------------------------
// hgpt_pick
// signed section index and slope tests choosing the hexagon in a section
// ----------------------------------------------------------------------------
module hgpt_pick (
    input  logic                        clk,
    input  logic                        en,
    input  logic [hgpt_pkg::Q_W-1:0]    quot_x,
    input  logic [hgpt_pkg::R_W-1:0]    rem_x,
    input  logic                        neg_x,
    input  logic [hgpt_pkg::Q_W-1:0]    quot_y,
    input  logic [hgpt_pkg::R_W-1:0]    rem_y,
    input  logic                        neg_y,
    output logic signed [hgpt_pkg::TC_W-1:0] tile_col,
    output logic signed [hgpt_pkg::TC_W-1:0] tile_row
);
    import hgpt_pkg::*;

    localparam logic signed [SL_W-1:0]  M_C    = SL_W'(SLOPE_M);
    localparam logic signed [SL_W-1:0]  HALF_C = SL_W'(EDGE_HALF);
    localparam logic signed [SL_W-1:0]  FULL_C = SL_W'(EDGE_FULL);
    localparam logic signed [OFS_W-1:0] MID_C  = OFS_W'(HALF_X);

    logic signed [TC_W-1:0]  sect_x;
    logic signed [TC_W-1:0]  sect_y;
    logic signed [OFS_W-1:0] pix_x;
    logic signed [OFS_W-1:0] pix_y;
    logic signed [SL_W-1:0]  y64;
    logic signed [SL_W-1:0]  x31;
    logic                    hit_left;
    logic                    hit_right;
    logic                    dec_col;
    logic                    dec_row;
    logic signed [TC_W-1:0]  tile_col_reg;
    logic signed [TC_W-1:0]  tile_row_reg;

    always_comb
    begin
        // truncation toward zero: apply the sign to the magnitudes
        sect_x = neg_x ? -TC_W'(quot_x) : TC_W'(quot_x);
        sect_y = neg_y ? -TC_W'(quot_y) : TC_W'(quot_y);
        pix_x  = neg_x ? -OFS_W'(rem_x >> 4) : OFS_W'(rem_x >> 4);
        pix_y  = neg_y ? -OFS_W'(rem_y >> 4) : OFS_W'(rem_y >> 4);
        y64    = SL_W'(pix_y) <<< 6;
        x31    = SL_W'(pix_x) * M_C;

        hit_left  = 1'b0;
        hit_right = 1'b0;
        dec_col   = 1'b0;
        dec_row   = 1'b0;
        if (!quot_y[0])
        begin
            // even row: upper-left edge, upper-right edge wins when both hit
            hit_left  = (y64 < HALF_C - x31);
            hit_right = (y64 < x31 - HALF_C);
            dec_row   = hit_left || hit_right;
            dec_col   = hit_left && !hit_right;
        end
        else if (pix_x >= MID_C)
        begin
            dec_row = (y64 < FULL_C - x31);
        end
        else
        begin
            dec_row = (y64 < x31);
            dec_col = !dec_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tile_col_reg <= sect_x - TC_W'(dec_col);
            tile_row_reg <= sect_y - TC_W'(dec_row);
        end
    end

    assign tile_col = tile_col_reg;
    assign tile_row = tile_row_reg;

endmodule

// ===== rtl/hgpt_sat.sv =====
// ----------------------------------------------------------------------------
// hgpt_sat
// relative tile saturation, chunk offset add and absolute saturation
// ----------------------------------------------------------------------------
module hgpt_sat (
    input  logic                              clk,
    input  hgpt_pkg::pipe_en_t                en,
    input  logic signed [hgpt_pkg::TC_W-1:0]  tile_col,
    input  logic signed [hgpt_pkg::TC_W-1:0]  tile_row,
    input  logic signed [hgpt_pkg::CT_W-1:0]  chunk_tiles_col,
    input  logic signed [hgpt_pkg::CT_W-1:0]  chunk_tiles_row,
    output logic signed [hgpt_pkg::REL_W-1:0] rel_tile_col,
    output logic signed [hgpt_pkg::REL_W-1:0] rel_tile_row,
    output logic signed [hgpt_pkg::ABS_W-1:0] abs_tile_col,
    output logic signed [hgpt_pkg::ABS_W-1:0] abs_tile_row
);
    import hgpt_pkg::*;

    localparam logic signed [TC_W-1:0]  REL_MAX = TC_W'((1 << (REL_W - 1)) - 1);
    localparam logic signed [TC_W-1:0]  REL_MIN = -TC_W'(1 << (REL_W - 1));
    localparam logic signed [SUM_W-1:0] ABS_MAX = SUM_W'((1 << (ABS_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] ABS_MIN = -SUM_W'(1 << (ABS_W - 1));

    logic signed [REL_W-1:0] rel_col_sat;
    logic signed [REL_W-1:0] rel_row_sat;
    logic signed [REL_W-1:0] rel_col_reg;
    logic signed [REL_W-1:0] rel_row_reg;
    logic signed [SUM_W-1:0] sum_col_reg;
    logic signed [SUM_W-1:0] sum_row_reg;
    logic signed [REL_W-1:0] rel_col_out_reg;
    logic signed [REL_W-1:0] rel_row_out_reg;
    logic signed [ABS_W-1:0] abs_col_reg;
    logic signed [ABS_W-1:0] abs_row_reg;

    function automatic logic signed [ABS_W-1:0] sat_abs(input logic signed [SUM_W-1:0] v);
        logic signed [ABS_W-1:0] r;
        if (v > ABS_MAX)
            r = ABS_W'(ABS_MAX);
        else if (v < ABS_MIN)
            r = ABS_W'(ABS_MIN);
        else
            r = ABS_W'(v);
        return r;
    endfunction

    always_comb
    begin
        if (tile_col > REL_MAX)
            rel_col_sat = REL_W'(REL_MAX);
        else if (tile_col < REL_MIN)
            rel_col_sat = REL_W'(REL_MIN);
        else
            rel_col_sat = REL_W'(tile_col);

        if (tile_row > REL_MAX)
            rel_row_sat = REL_W'(REL_MAX);
        else if (tile_row < REL_MIN)
            rel_row_sat = REL_W'(REL_MIN);
        else
            rel_row_sat = REL_W'(tile_row);
    end

    always_ff @(posedge clk)
    begin
        if (en.first)
        begin
            rel_col_reg <= rel_col_sat;
            rel_row_reg <= rel_row_sat;
            sum_col_reg <= SUM_W'(rel_col_sat) + SUM_W'(chunk_tiles_col);
            sum_row_reg <= SUM_W'(rel_row_sat) + SUM_W'(chunk_tiles_row);
        end
        if (en.second)
        begin
            rel_col_out_reg <= rel_col_reg;
            rel_row_out_reg <= rel_row_reg;
            abs_col_reg     <= sat_abs(sum_col_reg);
            abs_row_reg     <= sat_abs(sum_row_reg);
        end
    end

    assign rel_tile_col = rel_col_out_reg;
    assign rel_tile_row = rel_row_out_reg;
    assign abs_tile_col = abs_col_reg;
    assign abs_tile_row = abs_row_reg;

endmodule

// ===== rtl/hex_grid_point_to_tile.sv =====
// ----------------------------------------------------------------------------
// hex_grid_point_to_tile
// maps a fixed point world position to the pointy-top hexagon under it
// ----------------------------------------------------------------------------
// throughput: one point per cycle, set by the seven-stage pipeline with no
//   shared unit; the input stalls only when all seven stages hold points and
//   the output register is held by tready
// reset: clears the chunk origin and tile offset registers and all stage
//   valid bits; payload registers are not reset
// a chunk register write already applies to the point accepted at the next edge
// ----------------------------------------------------------------------------
module hex_grid_point_to_tile #(
    parameter int TILES_PER_CHUNK = hgpt_pkg::TILES_PER_CHUNK_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,

    // configuration write port
    input  logic                         cfg_we,
    input  logic [hgpt_pkg::IDX_W-1:0]   cfg_index,
    input  logic [hgpt_pkg::CFG_W-1:0]   cfg_data,

    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hgpt_pkg::IN_W-1:0]    s_tdata,   // point_x[27:0], point_y[55:28]

    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [hgpt_pkg::OUT_W-1:0]   m_tdata    // rel_tile_col[17:0], rel_tile_row[35:18],
                                                    // abs_tile_col[54:36], abs_tile_row[73:55],
                                                    // zero fill[79:74]
);
    import hgpt_pkg::*;

    // chunk size in 1/16 px; the height snaps the chunk to whole pixels
    localparam int CHUNK_W16 = TILES_PER_CHUNK * SECT_W16;
    localparam int CHUNK_H16 = ((TILES_PER_CHUNK * SECT_H16 + 465) / 16) * 16 - 465;

    localparam logic signed [ORG_W-1:0] CHUNK_W_C = ORG_W'(CHUNK_W16);
    localparam logic signed [ORG_W-1:0] CHUNK_H_C = ORG_W'(CHUNK_H16);
    localparam logic signed [CT_W-1:0]  TPC_C     = CT_W'(TILES_PER_CHUNK);

    // ------------------------------------------------------------------
    // configuration: chunk origin and tile offset
    // ------------------------------------------------------------------
    logic signed [CFG_W-1:0] cfg_value;
    logic signed [ORG_W-1:0] origin_x_reg;
    logic signed [ORG_W-1:0] origin_y_reg;
    logic signed [CT_W-1:0]  tiles_col_reg;
    logic signed [CT_W-1:0]  tiles_row_reg;

    assign cfg_value = cfg_data;

    // a write stores the derived products directly, so they change at the
    // same edge as the chunk coordinate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            tiles_col_reg <= '0;
            tiles_row_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CHUNK_COL:
                begin
                    origin_x_reg  <= ORG_W'(cfg_value * CHUNK_W_C);
                    tiles_col_reg <= CT_W'(cfg_value * TPC_C);
                end
                REG_CHUNK_ROW:
                begin
                    origin_y_reg  <= ORG_W'(cfg_value * CHUNK_H_C);
                    tiles_row_reg <= CT_W'(cfg_value * TPC_C);
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valid bits and advance enables
    //   stage 1  relative point        stage 5  section index, slope tests
    //   stage 2  sign and magnitude    stage 6  relative saturation, offset add
    //   stage 3  reciprocal multiply   stage 7  absolute saturation (output)
    //   stage 4  remainder correction
    // a stage moves on when it is empty or the next one moves, so bubbles
    // collapse and new points enter while a result waits, until all stages hold one
    // ------------------------------------------------------------------
    logic [STAGES:1] valid_reg;
    logic [STAGES:1] adv;

    always_comb
    begin
        adv[STAGES] = !valid_reg[STAGES] || m_tready;
        for (int i = STAGES - 1; i >= 1; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
                valid_reg[1] <= s_tvalid;
            for (int i = 2; i <= STAGES; i++)
            begin
                if (adv[i])
                    valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    assign s_tready = adv[1];
    assign m_tvalid = valid_reg[STAGES];

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;

    assign point_x = s_tdata[PT_W-1:0];
    assign point_y = s_tdata[2*PT_W-1:PT_W];

    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;

    // stages 1-2: chunk-relative point, split into sign and magnitude
    hgpt_front u_front (
        .clk      (clk),
        .en       ('{first: adv[1], second: adv[2]}),
        .point_x  (point_x),
        .point_y  (point_y),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .neg_x    (neg_x),
        .neg_y    (neg_y),
        .mag_x    (mag_x),
        .mag_y    (mag_y)
    );

    // stages 3-4: magnitudes divided into section index and remainder
    logic [Q_W-1:0] quot_x;
    logic [Q_W-1:0] quot_y;
    logic [R_W-1:0] rem_x;
    logic [R_W-1:0] rem_y;

    hgpt_cdiv #(.DIV(SECT_W16)) u_div_x (
        .clk      (clk),
        .en       ('{first: adv[3], second: adv[4]}),
        .dividend (mag_x),
        .quot     (quot_x),
        .rem      (rem_x)
    );

    hgpt_cdiv #(.DIV(SECT_H16)) u_div_y (
        .clk      (clk),
        .en       ('{first: adv[3], second: adv[4]}),
        .dividend (mag_y),
        .quot     (quot_y),
        .rem      (rem_y)
    );

    // signs travel alongside the dividers
    logic neg_x3_reg;
    logic neg_y3_reg;
    logic neg_x4_reg;
    logic neg_y4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            neg_x3_reg <= neg_x;
            neg_y3_reg <= neg_y;
        end
        if (adv[4])
        begin
            neg_x4_reg <= neg_x3_reg;
            neg_y4_reg <= neg_y3_reg;
        end
    end

    // stage 5: signed section index and neighbour choice
    logic signed [TC_W-1:0] tile_col;
    logic signed [TC_W-1:0] tile_row;

    hgpt_pick u_pick (
        .clk      (clk),
        .en       (adv[5]),
        .quot_x   (quot_x),
        .rem_x    (rem_x),
        .neg_x    (neg_x4_reg),
        .quot_y   (quot_y),
        .rem_y    (rem_y),
        .neg_y    (neg_y4_reg),
        .tile_col (tile_col),
        .tile_row (tile_row)
    );

    // stages 6-7: saturation and absolute tile, stage 7 is the output register
    logic signed [REL_W-1:0] rel_tile_col;
    logic signed [REL_W-1:0] rel_tile_row;
    logic signed [ABS_W-1:0] abs_tile_col;
    logic signed [ABS_W-1:0] abs_tile_row;

    hgpt_sat u_sat (
        .clk             (clk),
        .en              ('{first: adv[6], second: adv[7]}),
        .tile_col        (tile_col),
        .tile_row        (tile_row),
        .chunk_tiles_col (tiles_col_reg),
        .chunk_tiles_row (tiles_row_reg),
        .rel_tile_col    (rel_tile_col),
        .rel_tile_row    (rel_tile_row),
        .abs_tile_col    (abs_tile_col),
        .abs_tile_row    (abs_tile_row)
    );

    assign m_tdata = {{OUT_PAD{1'b0}}, abs_tile_row, abs_tile_col, rel_tile_row, rel_tile_col};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // an empty output register means the whole pipe can move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register is empty");

    // every input transfer lands in the first stage
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[1])
        else $error("accepted point did not enter the pipeline");

    // the correction step leaves remainders inside one section
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] |-> ((rem_x < R_W'(SECT_W16)) && (rem_y < R_W'(SECT_H16))))
        else $error("section remainder out of range");

endmodule
